[hw/rtl/lgs_pkg.sv]
// lgs_pkg: shared types and constants for the life grid generation step block
// item payload structs, action codes and register indexes
// no dependencies
`default_nettype none

package lgs_pkg;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_TICK  = 2'd2
  } action_e;

  localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;

  localparam int unsigned DimW = 7;

  typedef struct packed {
    logic [1:0] action;
    logic [5:0] col;
    logic [5:0] row;
    logic       cell_in;
  } in_item_t;

  typedef struct packed {
    logic cell_out;
    logic generation_done;
  } out_item_t;

  typedef struct packed {
    logic [1:0]      index;
    logic [DimW-1:0] wdata;
  } cfg_wr_t;

endpackage

`default_nettype wire

[hw/rtl/lgs_chan_if.sv]
// lgs_chan_if: valid/ready channel carrying one payload of a given type
// used for the item, result and configuration channels; payload types in lgs_pkg
`default_nettype none

interface lgs_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/lgs_row_unit.sv]
// lgs_row_unit: next generation of one whole grid row under the b3/s23 rule
// shared by every row of a tick; columns at or beyond the mask count as dead
`default_nettype none

module lgs_row_unit #(
  parameter int unsigned MAX_COLS = 64
) (
  input  wire logic [MAX_COLS-1:0] above_i,
  input  wire logic [MAX_COLS-1:0] cur_i,
  input  wire logic [MAX_COLS-1:0] below_i,
  input  wire logic [MAX_COLS-1:0] mask_i,
  output logic      [MAX_COLS-1:0] next_o
);

  logic [MAX_COLS+1:0] ap, cp, bp;

  // one dead column padded on each side so the edges need no special case
  assign ap = {1'b0, above_i & mask_i, 1'b0};
  assign cp = {1'b0, cur_i & mask_i, 1'b0};
  assign bp = {1'b0, below_i & mask_i, 1'b0};

  always_comb begin
    logic [3:0] n;
    next_o = '0;
    for (int c = 0; c < MAX_COLS; c++) begin
      n = 4'(ap[c]) + 4'(ap[c+1]) + 4'(ap[c+2])
        + 4'(cp[c]) + 4'(cp[c+2])
        + 4'(bp[c]) + 4'(bp[c+1]) + 4'(bp[c+2]);
      next_o[c] = mask_i[c] & ((n == 4'd3) | (cp[c+1] & (n == 4'd2)));
    end
  end

endmodule

`default_nettype wire

[hw/rtl/life_grid_generation_step_core.sv]
// life_grid_generation_step_core: game of life grid with cell write/read and generation tick
// uses lgs_pkg, lgs_chan_if and lgs_row_unit
//
//   channel   dir   payload                          handshake
//   in_i      in    action, col, row, cell_in        valid/ready
//   out_o     out   cell_out, generation_done        valid/ready
//   cfg_i     in    index, wdata                     valid/ready, always ready
//
// write and read items: the write or read state, then the finishing state loads the result.
// tick item: rows 0 and 1 are prefetched in the load and prime states, then one row a cycle
// through the shared row unit; the finishing state loads the result and returns to idle.
// reset clears every row at once through per-row valid bits; no clearing pass.
// a new item is taken only in idle; a stalled result holds the block in its last state.
`default_nettype none

module life_grid_generation_step_core #(
  parameter int unsigned MAX_COLS = 64,
  parameter int unsigned MAX_ROWS = 64
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  lgs_chan_if.sink   in_i,
  lgs_chan_if.source out_o,
  lgs_chan_if.sink   cfg_i
);

  localparam int unsigned DW = lgs_pkg::DimW;
  localparam int unsigned CW = $clog2(MAX_COLS);
  localparam int unsigned RW = $clog2(MAX_ROWS);
  localparam logic [DW-1:0] WLim = DW'(MAX_COLS);
  localparam logic [DW-1:0] HLim = (MAX_ROWS > 127) ? 7'd127 : DW'(MAX_ROWS);

  typedef enum logic [2:0] {
    S_IDLE, S_WR, S_RD, S_TK_LOAD, S_TK_PRIME, S_TK_RUN, S_FIN
  } state_e;

  state_e                state_q;
  logic [DW-1:0]         gw_q, gh_q;
  logic [DW-1:0]         eff_w, eff_h;
  logic [DW-1:0]         y_q;
  logic [MAX_COLS-1:0]   cur_q, above_q;
  logic [5:0]            col_q, row_q;
  logic                  cell_q, inside_q;
  logic                  res_cell_q, res_gen_q;
  logic                  out_valid_q, out_cell_q, out_gen_q;
  logic [MAX_ROWS-1:0]   row_vld_q;
  logic                  rd_vld_q;
  logic [MAX_COLS-1:0]   rdata_q, rd_eff;
  logic [MAX_COLS-1:0]   mem [MAX_ROWS];
  logic [MAX_COLS-1:0]   mask, below, nxt, wr_row, wdata;
  logic [7:0]            ra8, wa8;
  logic [RW-1:0]         raddr, waddr;
  logic                  we, inside_in, out_free;
  logic [CW-1:0]         col_idx;

  // register clamping: zero acts as one, large values stop at the grid size
  assign eff_w = (gw_q == '0) ? DW'(1) : ((gw_q > WLim) ? WLim : gw_q);
  assign eff_h = (gh_q == '0) ? DW'(1) : ((gh_q > HLim) ? HLim : gh_q);

  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      mask[c] = DW'(c) < eff_w;
    end
  end

  assign inside_in = ({1'b0, in_i.data.col} < eff_w) && ({1'b0, in_i.data.row} < eff_h);
  assign rd_eff    = rd_vld_q ? rdata_q : '0;
  assign col_idx   = col_q[CW-1:0];
  assign below     = ((y_q + DW'(1)) < eff_h) ? rd_eff : '0;
  assign out_free  = !out_valid_q || out_o.ready;

  lgs_row_unit #(
    .MAX_COLS(MAX_COLS)
  ) u_row_unit (
    .above_i(above_q),
    .cur_i  (cur_q),
    .below_i(below),
    .mask_i (mask),
    .next_o (nxt)
  );

  always_comb begin
    wr_row          = rd_eff;
    wr_row[col_idx] = cell_q;
  end

  always_comb begin
    unique case (state_q)
      S_TK_LOAD:  ra8 = 8'd0;
      S_TK_PRIME: ra8 = 8'd1;
      S_TK_RUN:   ra8 = 8'(y_q) + 8'd2;
      default:    ra8 = {2'b00, in_i.data.row};
    endcase
    raddr = ra8[RW-1:0];
    if (state_q == S_WR) begin
      we    = inside_q;
      wa8   = {2'b00, row_q};
      wdata = wr_row;
    end else begin
      we    = (state_q == S_TK_RUN);
      wa8   = 8'(y_q);
      // cells stored beyond the area in use keep their old value
      wdata = (cur_q & ~mask) | nxt;
    end
    waddr = wa8[RW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.data.cell_out        = out_cell_q;
  assign out_o.data.generation_done = out_gen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      gw_q        <= 7'd64;
      gh_q        <= 7'd64;
      y_q         <= '0;
      cur_q       <= '0;
      above_q     <= '0;
      col_q       <= '0;
      row_q       <= '0;
      cell_q      <= 1'b0;
      inside_q    <= 1'b0;
      res_cell_q  <= 1'b0;
      res_gen_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_cell_q  <= 1'b0;
      out_gen_q   <= 1'b0;
      row_vld_q   <= '0;
      rd_vld_q    <= 1'b0;
    end else begin
      rd_vld_q <= row_vld_q[raddr];
      if (we) begin
        row_vld_q[waddr] <= 1'b1;
      end
      if (cfg_i.valid) begin
        unique case (cfg_i.data.index)
          lgs_pkg::REG_GRID_WIDTH:  gw_q <= cfg_i.data.wdata;
          lgs_pkg::REG_GRID_HEIGHT: gh_q <= cfg_i.data.wdata;
          default: ;
        endcase
      end
      // the finishing state loads the next result itself
      if (out_o.ready && (state_q != S_FIN)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            col_q      <= in_i.data.col;
            row_q      <= in_i.data.row;
            cell_q     <= in_i.data.cell_in;
            inside_q   <= inside_in;
            res_cell_q <= 1'b0;
            res_gen_q  <= 1'b0;
            unique case (in_i.data.action)
              lgs_pkg::ACT_WRITE: state_q <= S_WR;
              lgs_pkg::ACT_READ:  state_q <= S_RD;
              lgs_pkg::ACT_TICK:  state_q <= S_TK_LOAD;
              default:            state_q <= S_FIN;
            endcase
          end
        end
        S_WR: begin
          state_q <= S_FIN;
        end
        S_RD: begin
          res_cell_q <= inside_q & rd_eff[col_idx];
          state_q    <= S_FIN;
        end
        S_TK_LOAD: begin
          state_q <= S_TK_PRIME;
        end
        S_TK_PRIME: begin
          cur_q   <= rd_eff;
          above_q <= '0;
          y_q     <= '0;
          state_q <= S_TK_RUN;
        end
        S_TK_RUN: begin
          // slide the window: old current row becomes the row above
          above_q <= cur_q;
          cur_q   <= rd_eff;
          y_q     <= y_q + DW'(1);
          if ((y_q + DW'(1)) == eff_h) begin
            res_gen_q <= 1'b1;
            state_q   <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_cell_q  <= res_cell_q;
            out_gen_q   <= res_gen_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
